@@ rtl/core/qvr_pkg.sv @@
// package for the quaternion vector rotation core
// holds the control and status structs shared by the core and its matrix stage
// no dependencies

package qvr_pkg;

  // stage enables and the incoming valid, driven by the core
  typedef struct packed {
    logic in_valid;
    logic en_prod;
    logic en_mat;
  } qvr_dcm_ctrl_t;

  // occupancy of the two matrix stages
  typedef struct packed {
    logic prod_valid;
    logic mat_valid;
  } qvr_dcm_stat_t;

endpackage

@@ rtl/core/qvr_if.sv @@
// valid/ready channel interfaces for the quaternion vector rotation core
// qvr_in_if carries quaternion, vector and func; qvr_out_if the rotated vector
// no dependencies

interface qvr_in_if #(
  parameter int QUAT_BITS = 16,
  parameter int VEC_BITS  = 24
);
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic signed [QUAT_BITS-1:0] quat_w;
  logic signed [QUAT_BITS-1:0] quat_x;
  logic signed [QUAT_BITS-1:0] quat_y;
  logic signed [QUAT_BITS-1:0] quat_z;
  logic signed [VEC_BITS-1:0]  vec_in_x;
  logic signed [VEC_BITS-1:0]  vec_in_y;
  logic signed [VEC_BITS-1:0]  vec_in_z;

  modport source (
    output valid, func, quat_w, quat_x, quat_y, quat_z, vec_in_x, vec_in_y, vec_in_z,
    input  ready
  );
  modport sink (
    input  valid, func, quat_w, quat_x, quat_y, quat_z, vec_in_x, vec_in_y, vec_in_z,
    output ready
  );
endinterface

interface qvr_out_if #(
  parameter int VEC_BITS = 24
);
  logic                       valid;
  logic                       ready;
  logic signed [VEC_BITS-1:0] vec_out_x;
  logic signed [VEC_BITS-1:0] vec_out_y;
  logic signed [VEC_BITS-1:0] vec_out_z;
  logic                       overflow;

  modport source (
    output valid, vec_out_x, vec_out_y, vec_out_z, overflow,
    input  ready
  );
  modport sink (
    input  valid, vec_out_x, vec_out_y, vec_out_z, overflow,
    output ready
  );
endinterface

@@ rtl/core/qvr_dcm.sv @@
// direction-cosine matrix stages: quaternion products, then matrix entries
// two register stages; uses qvr_pkg for the control and status structs

module qvr_dcm
  import qvr_pkg::*;
#(
  parameter int QUAT_BITS = 16,
  parameter int VEC_BITS  = 24,
  parameter int MAT_W     = 2 * QUAT_BITS + 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  qvr_dcm_ctrl_t               ctrl,
  output qvr_dcm_stat_t               stat,
  input  logic                        func,
  input  logic signed [QUAT_BITS-1:0] quat_w,
  input  logic signed [QUAT_BITS-1:0] quat_x,
  input  logic signed [QUAT_BITS-1:0] quat_y,
  input  logic signed [QUAT_BITS-1:0] quat_z,
  input  logic signed [VEC_BITS-1:0]  vec [3],
  output logic signed [MAT_W-1:0]     mat [3][3],
  output logic signed [VEC_BITS-1:0]  mat_vec [3]
);

  localparam int PROD_W = 2 * QUAT_BITS;

  // stage 1: the ten quaternion products
  logic signed [PROD_W-1:0]   ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic signed [VEC_BITS-1:0] prod_vec [3];
  logic                       prod_func;
  logic                       prod_valid;

  // stage 2: matrix, already transposed when func asks for it
  logic signed [MAT_W-1:0]    m [9];
  logic signed [MAT_W-1:0]    m_sel [3][3];
  logic                       mat_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ctrl.en_prod) begin
      prod_valid <= ctrl.in_valid;
    end
    if (ctrl.en_prod) begin
      ww        <= quat_w * quat_w;
      xx        <= quat_x * quat_x;
      yy        <= quat_y * quat_y;
      zz        <= quat_z * quat_z;
      xy        <= quat_x * quat_y;
      wz        <= quat_w * quat_z;
      xz        <= quat_x * quat_z;
      wy        <= quat_w * quat_y;
      yz        <= quat_y * quat_z;
      wx        <= quat_w * quat_x;
      prod_vec  <= vec;
      prod_func <= func;
    end
  end

  always_comb begin
    m[0] = MAT_W'(ww) + MAT_W'(xx) - MAT_W'(yy) - MAT_W'(zz);
    m[1] = (MAT_W'(xy) + MAT_W'(wz)) <<< 1;
    m[2] = (MAT_W'(xz) - MAT_W'(wy)) <<< 1;
    m[3] = (MAT_W'(xy) - MAT_W'(wz)) <<< 1;
    m[4] = MAT_W'(ww) - MAT_W'(xx) + MAT_W'(yy) - MAT_W'(zz);
    m[5] = (MAT_W'(yz) + MAT_W'(wx)) <<< 1;
    m[6] = (MAT_W'(xz) + MAT_W'(wy)) <<< 1;
    m[7] = (MAT_W'(yz) - MAT_W'(wx)) <<< 1;
    m[8] = MAT_W'(ww) - MAT_W'(xx) - MAT_W'(yy) + MAT_W'(zz);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_sel[i][j] = prod_func ? m[3 * j + i] : m[3 * i + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_valid <= 1'b0;
    end else if (ctrl.en_mat) begin
      mat_valid <= prod_valid;
    end
    if (ctrl.en_mat) begin
      mat     <= m_sel;
      mat_vec <= prod_vec;
    end
  end

  assign stat.prod_valid = prod_valid;
  assign stat.mat_valid  = mat_valid;

endmodule

@@ rtl/core/quaternion_vector_rotate_core.sv @@
// quaternion vector rotation core, top level
// depends on qvr_pkg, qvr_in_if / qvr_out_if and qvr_dcm
//
// usage:
//   din carries one beat per item: func, a Q1.(QUAT_BITS-1) quaternion
//   (quat_w..quat_z) and a signed VEC_BITS vector (vec_in_x..z).
//   dout returns one beat per item: the vector times the direction-cosine
//   matrix (func 0) or its transpose (func 1), rounded half up from
//   2*(QUAT_BITS-1) fraction bits and saturated, overflow set on any clamp.
//   the quaternion is not normalized; the matrix is built from raw products.
// pipeline: five register stages from the din beat to dout.valid (products,
//   matrix, matrix-vector multiply, three-term sum with rounding, saturation).
// throughput: one beat per cycle while dout is taken, set by the five-stage
//   register pipeline; every stage holds one item, and the product and
//   matrix-vector stages each have their own full set of multipliers.
// stall: each stage advances when it is empty or the stage after it moves,
//   so bubbles close up while dout is held; din.ready drops only when all
//   five stages are full. a held result stays stable until taken.
// reset: rst clears the stage valid bits only; the block takes a beat in
//   the first cycle after reset.

module quaternion_vector_rotate_core
  import qvr_pkg::*;
#(
  parameter int QUAT_BITS = 16,
  parameter int VEC_BITS  = 24
) (
  input  logic             clk,
  input  logic             rst,
  qvr_in_if.sink           din,
  qvr_out_if.source        dout
);

  // entry width: 2(xy+wz) reaches 2^(2*QUAT_BITS) at full scale
  localparam int MAT_W  = 2 * QUAT_BITS + 2;
  localparam int PROD_W = MAT_W + VEC_BITS;
  // three products summed, plus room for the rounding constant
  localparam int ACC_W  = PROD_W + 2;
  localparam int FRAC   = 2 * (QUAT_BITS - 1);
  localparam int SH_W   = ACC_W - FRAC;
  localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC - 1);
  localparam logic [VEC_BITS-1:0] VEC_MAX = {1'b0, {(VEC_BITS-1){1'b1}}};
  localparam logic [VEC_BITS-1:0] VEC_MIN = {1'b1, {(VEC_BITS-1){1'b0}}};

  qvr_dcm_ctrl_t dcm_ctrl;
  qvr_dcm_stat_t dcm_stat;

  logic signed [VEC_BITS-1:0] vec_in [3];
  logic signed [MAT_W-1:0]    mat [3][3];
  logic signed [VEC_BITS-1:0] mat_vec [3];

  // stage 3: matrix times vector, nine products
  logic signed [PROD_W-1:0]   prod [3][3];
  logic                       mul_valid;
  // stage 4: row sums with the rounding half added
  logic signed [ACC_W-1:0]    acc [3];
  logic                       acc_valid;
  // stage 5 sits in the output register
  logic                       out_valid;
  logic [VEC_BITS-1:0]        res [3];
  logic                       res_ovf;
  logic [VEC_BITS-1:0]        res_next [3];
  logic [2:0]                 clamp;

  // per-stage enables, from the output back
  logic en_out, en_acc, en_mul, en_mat, en_prod;

  assign en_out  = !out_valid || dout.ready;
  assign en_acc  = !acc_valid || en_out;
  assign en_mul  = !mul_valid || en_acc;
  assign en_mat  = !dcm_stat.mat_valid || en_mul;
  assign en_prod = !dcm_stat.prod_valid || en_mat;

  assign din.ready = en_prod;

  assign dcm_ctrl.in_valid = din.valid;
  assign dcm_ctrl.en_prod  = en_prod;
  assign dcm_ctrl.en_mat   = en_mat;

  assign vec_in[0] = din.vec_in_x;
  assign vec_in[1] = din.vec_in_y;
  assign vec_in[2] = din.vec_in_z;

  qvr_dcm #(
    .QUAT_BITS (QUAT_BITS),
    .VEC_BITS  (VEC_BITS),
    .MAT_W     (MAT_W)
  ) u_dcm (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (dcm_ctrl),
    .stat    (dcm_stat),
    .func    (din.func),
    .quat_w  (din.quat_w),
    .quat_x  (din.quat_x),
    .quat_y  (din.quat_y),
    .quat_z  (din.quat_z),
    .vec     (vec_in),
    .mat     (mat),
    .mat_vec (mat_vec)
  );

  // matrix-vector products
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (en_mul) begin
      mul_valid <= dcm_stat.mat_valid;
    end
    if (en_mul) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= mat[i][j] * mat_vec[j];
        end
      end
    end
  end

  // exact row sums, half an lsb added for round-half-up
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (en_acc) begin
      acc_valid <= mul_valid;
    end
    if (en_acc) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= ACC_W'(prod[i][0]) + ACC_W'(prod[i][1]) + ACC_W'(prod[i][2]) + HALF;
      end
    end
  end

  // drop the fraction, clamp when the bits above the result are not all sign
  always_comb begin
    logic [SH_W-1:0]         sh;
    logic [SH_W-VEC_BITS:0]  top;
    for (int i = 0; i < 3; i++) begin
      sh  = acc[i][ACC_W-1:FRAC];
      top = sh[SH_W-1:VEC_BITS-1];
      if ((&top) || !(|top)) begin
        res_next[i] = sh[VEC_BITS-1:0];
        clamp[i]    = 1'b0;
      end else begin
        res_next[i] = sh[SH_W-1] ? VEC_MIN : VEC_MAX;
        clamp[i]    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= acc_valid;
    end
    if (en_out) begin
      res     <= res_next;
      res_ovf <= |clamp;
    end
  end

  assign dout.valid     = out_valid;
  assign dout.vec_out_x = res[0];
  assign dout.vec_out_y = res[1];
  assign dout.vec_out_z = res[2];
  assign dout.overflow  = res_ovf;

endmodule
